>>> src/bscc_pkg.sv
package bscc_pkg;

    // store geometry
    localparam int BLOCK_COUNT = 8;
    localparam int IDX_W       = $clog2(BLOCK_COUNT);

    // field widths
    localparam int BYTE_W = 8;
    localparam int CRC_W  = 32;

    // reflected crc-32
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    // one byte through the reflected crc, lsb first
    function automatic logic [CRC_W-1:0] crc32_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/block_scrub_crc_compare_unit.sv
// a last byte is registered in the compare stage, then in the output register (m_tvalid)
// one byte transfer per cycle unless results stall; bytes without tlast give no result
// the checksum store is an 8 x 32 memory with registered read, written back on a miss;
// a write to the entry being read in the same cycle is forwarded
// reset clears the running crcs, the difference flag and the per-block valid bits;
// the store itself is not cleared, entries are only trusted once their valid bit is set
module block_scrub_crc_compare_unit
    import bscc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // block_index[2:0], flash_byte[10:3], backup_byte[18:11], zero fill
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // done_block[2:0], rewrite[3], checksum_hit[4], backup_checksum[36:5], zero fill
    output logic [39:0] m_tdata
);

    logic [IDX_W-1:0]  in_idx;
    logic [BYTE_W-1:0] in_fb;
    logic [BYTE_W-1:0] in_bb;
    logic              s_fire;
    logic              s_last_fire;
    logic              out_move;

    logic [CRC_W-1:0]  flash_crc;
    logic [CRC_W-1:0]  backup_crc;

    logic              differ_reg;
    logic              differ_next;
    logic              differ_now;

    // compare stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [CRC_W-1:0]  s1_fcrc_reg;
    logic [CRC_W-1:0]  s1_bcrc_reg;
    logic              s1_differ_reg;
    logic              s1_fwd_reg;
    logic [CRC_W-1:0]  s1_fwd_data_reg;
    logic [CRC_W-1:0]  rd_data_reg;
    logic [CRC_W-1:0]  s1_stored;
    logic              s1_hit;

    logic [CRC_W-1:0]  chk_mem [BLOCK_COUNT];
    logic [BLOCK_COUNT-1:0] chk_valid_reg;
    logic [BLOCK_COUNT-1:0] chk_valid_next;

    // output register
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [IDX_W-1:0]  out_block_reg;
    logic              out_rewrite_reg;
    logic              out_hit_reg;
    logic [CRC_W-1:0]  out_crc_reg;

    // unpack the input transfer
    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_fb  = s_tdata[IDX_W +: BYTE_W];
    assign in_bb  = s_tdata[IDX_W+BYTE_W +: BYTE_W];

    // handshake
    assign out_move    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready    = !s1_valid_reg || out_move;
    assign s_fire      = s_tvalid && s_tready;
    assign s_last_fire = s_fire && s_tlast;

    // running crcs over both streams
    bscc_crc_acc u_flash_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .feed      (s_fire),
        .restart   (s_tlast),
        .data      (in_fb),
        .crc_final (flash_crc)
    );

    bscc_crc_acc u_backup_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .feed      (s_fire),
        .restart   (s_tlast),
        .data      (in_bb),
        .crc_final (backup_crc)
    );

    // sticky byte difference flag
    assign differ_now = differ_reg || (in_fb != in_bb);

    always_comb begin
        differ_next = differ_reg;
        if (s_fire) begin
            differ_next = s_tlast ? 1'b0 : differ_now;
        end
    end

    // stored checksum, forwarded when the previous block wrote the same entry
    assign s1_stored = s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
    assign s1_hit    = chk_valid_reg[s1_idx_reg] && (s1_stored == s1_fcrc_reg);

    // valid bits and stage control
    always_comb begin
        chk_valid_next = chk_valid_reg;
        if (out_move && !s1_hit) begin
            chk_valid_next[s1_idx_reg] = 1'b1;
        end
        s1_valid_next = s1_valid_reg;
        if (s_last_fire) begin
            s1_valid_next = 1'b1;
        end else if (out_move) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            differ_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            chk_valid_reg <= '0;
        end else begin
            differ_reg    <= differ_next;
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    // checksum memory: read on a last byte, write back on a miss
    always_ff @(posedge aclk) begin
        if (out_move && !s1_hit) begin
            chk_mem[s1_idx_reg] <= s1_bcrc_reg;
        end
        if (s_last_fire) begin
            rd_data_reg <= chk_mem[in_idx];
        end
    end

    // compare stage payload
    always_ff @(posedge aclk) begin
        if (s_last_fire) begin
            s1_idx_reg      <= in_idx;
            s1_fcrc_reg     <= flash_crc;
            s1_bcrc_reg     <= backup_crc;
            s1_differ_reg   <= differ_now;
            s1_fwd_reg      <= out_move && !s1_hit && (s1_idx_reg == in_idx);
            s1_fwd_data_reg <= s1_bcrc_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_move) begin
            out_block_reg   <= s1_idx_reg;
            out_rewrite_reg <= !s1_hit && s1_differ_reg;
            out_hit_reg     <= s1_hit;
            out_crc_reg     <= s1_bcrc_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_crc_reg, out_hit_reg, out_rewrite_reg, out_block_reg};

endmodule

>>> src/bscc_crc_acc.sv
module bscc_crc_acc
    import bscc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              feed,      // a byte is taken this cycle
    input  logic              restart,   // byte closes the block
    input  logic [BYTE_W-1:0] data,
    output logic [CRC_W-1:0]  crc_final  // finished crc including this byte
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_upd;

    // byte-wide update of the running value
    assign crc_upd   = crc32_byte(crc_reg, data);
    assign crc_final = crc_upd ^ CRC_ONES;

    always_comb begin
        crc_next = crc_reg;
        if (feed) begin
            crc_next = restart ? CRC_ONES : crc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_ONES;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

>>> bench/block_scrub_crc_compare_unit_tb.sv
`timescale 1ns / 100ps

module block_scrub_crc_compare_unit_tb;
    import bscc_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 100;
    localparam int IMAGE_MAX   = 16;
    localparam int DRAIN_WAIT  = 8;

    // one block verdict as seen on the result channel
    typedef struct packed {
        logic [IDX_W-1:0] blk;
        logic             rewrite;
        logic             hit;
        logic [CRC_W-1:0] crc;
    } verdict_t;

    // tracks the scrubber state and holds the verdicts still owed by the block
    class scrub_tracker;
        logic [CRC_W-1:0] flash_crc;
        logic [CRC_W-1:0] backup_crc;
        logic             differ;
        logic [CRC_W-1:0] stored_crc [BLOCK_COUNT];
        logic             stored_ok [BLOCK_COUNT];
        verdict_t         verdicts_due [$];
        int               bytes_seen;
        int               verdicts_seen;
        int               kept_count;
        int               rewrite_count;
        int               errors;

        function new();
            flash_crc     = CRC_ONES;
            backup_crc    = CRC_ONES;
            differ        = 1'b0;
            bytes_seen    = 0;
            verdicts_seen = 0;
            kept_count    = 0;
            rewrite_count = 0;
            errors        = 0;
            for (int i = 0; i < BLOCK_COUNT; i++) begin
                stored_crc[i] = '0;
                stored_ok[i]  = 1'b0;
            end
        endfunction

        // reflected crc-32, one data bit per step
        function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] c;
            logic             fbit;
            c = crc;
            for (int k = 0; k < BYTE_W; k++) begin
                fbit = c[0] ^ b[k];
                c    = c >> 1;
                if (fbit) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        // accepted byte pair: fold into both crcs, judge the block on its last byte
        function void note_byte(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] fb,
                                logic [BYTE_W-1:0] bb, logic last);
            verdict_t         v;
            logic [CRC_W-1:0] fcrc;
            bytes_seen++;
            flash_crc  = crc_step(flash_crc, fb);
            backup_crc = crc_step(backup_crc, bb);
            if (fb != bb) begin
                differ = 1'b1;
            end
            if (!last) begin
                return;
            end
            fcrc      = flash_crc ^ CRC_ONES;
            v.crc     = backup_crc ^ CRC_ONES;
            v.blk     = idx;
            v.hit     = 1'b0;
            v.rewrite = 1'b0;
            if (int'(idx) < BLOCK_COUNT) begin
                if (stored_ok[idx] && stored_crc[idx] == fcrc) begin
                    v.hit = 1'b1;
                end else begin
                    stored_crc[idx] = v.crc;
                    stored_ok[idx]  = 1'b1;
                    v.rewrite       = differ;
                end
            end
            verdicts_due.push_back(v);
            flash_crc  = CRC_ONES;
            backup_crc = CRC_ONES;
            differ     = 1'b0;
        endfunction

        // accepted result: compare against the oldest verdict owed
        function void check_verdict(logic [39:0] word);
            verdict_t v;
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual %h", $time, word);
                return;
            end
            v = verdicts_due.pop_front();
            if (word[2:0] != v.blk) begin
                errors++;
                $display("%0t: done_block expected %0d actual %0d", $time, v.blk, word[2:0]);
            end
            if (word[3] != v.rewrite) begin
                errors++;
                $display("%0t: rewrite expected %0b actual %0b", $time, v.rewrite, word[3]);
            end
            if (word[4] != v.hit) begin
                errors++;
                $display("%0t: checksum_hit expected %0b actual %0b", $time, v.hit, word[4]);
            end
            if (word[36:5] != v.crc) begin
                errors++;
                $display("%0t: backup_checksum expected %h actual %h", $time, v.crc,
                         word[36:5]);
            end
            if (v.hit) begin
                kept_count++;
            end
            if (v.rewrite) begin
                rewrite_count++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // block_index[2:0], flash_byte[10:3], backup_byte[18:11], zero fill
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    // done_block[2:0], rewrite[3], checksum_hit[4], backup_checksum[36:5], zero fill
    logic [39:0] m_tdata;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    scrub_tracker tracker;

    // backup image per block, reused so that later scans can hit the stored checksum
    logic [BYTE_W-1:0] image [BLOCK_COUNT][IMAGE_MAX];
    int                image_len [BLOCK_COUNT];
    bit                image_set [BLOCK_COUNT];

    block_scrub_crc_compare_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // result side: random back-pressure, held low in reset, check every accepted transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_verdict(m_tdata);
        end
        m_tready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("block_scrub_crc_compare_unit_tb: done, errors");
            $finish;
        end
    end

    // one byte-pair transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] fb,
                             input logic [BYTE_W-1:0] bb, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, bb, fb, idx};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tracker.note_byte(idx, fb, bb, last);
    endtask

    // fresh random backup image for a block
    task automatic fill_image(input int b);
        image_len[b] = $urandom_range(1, IMAGE_MAX);
        for (int i = 0; i < IMAGE_MAX; i++) begin
            image[b][i] = BYTE_W'($urandom_range(0, 255));
        end
        image_set[b] = 1'b1;
    endtask

    // scan a block image, flash bytes corrupted at the given rate, index may wander
    task automatic scan_image(input int b, input int corrupt_pct, input bit drift_idx);
        logic [BYTE_W-1:0] fb;
        logic [IDX_W-1:0]  idx;
        bit                last;
        for (int i = 0; i < image_len[b]; i++) begin
            fb   = image[b][i];
            last = (i == image_len[b] - 1);
            if ($urandom_range(99) < corrupt_pct) begin
                fb = fb ^ BYTE_W'($urandom_range(1, 255));
            end
            idx = (drift_idx && !last) ? IDX_W'($urandom_range(0, 7)) : IDX_W'(b);
            send_byte(idx, fb, image[b][i], last);
        end
    endtask

    // unrelated random bytes on both sides
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            send_byte(IDX_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)), i == n - 1);
        end
    endtask

    initial begin
        int target;
        int b;
        int pick;
        tracker  = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            image_set[i] = 1'b0;
            image_len[i] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme bytes and indexes, first visit of a block
        send_byte(3'd0, 8'h00, 8'h00, 1'b1);
        send_byte(3'd7, 8'hff, 8'hff, 1'b1);
        // clean rescan keeps the block
        send_byte(3'd0, 8'h00, 8'h00, 1'b1);
        // stored checksum valid but flash differs
        send_byte(3'd7, 8'hff, 8'hfe, 1'b1);
        send_byte(3'd7, 8'hfe, 8'hfe, 1'b1);
        // index wandering inside a block, last index decides
        send_byte(3'd5, 8'ha5, 8'ha5, 1'b0);
        send_byte(3'd1, 8'h5a, 8'h5b, 1'b0);
        send_byte(3'd3, 8'hff, 8'h00, 1'b1);
        send_byte(3'd3, 8'ha5, 8'ha5, 1'b0);
        send_byte(3'd3, 8'h5b, 8'h5b, 1'b0);
        send_byte(3'd3, 8'h00, 8'h00, 1'b1);
        // every byte differs
        send_byte(3'd2, 8'h00, 8'hff, 1'b0);
        send_byte(3'd2, 8'h00, 8'hff, 1'b0);
        send_byte(3'd2, 8'hff, 8'h00, 1'b0);
        send_byte(3'd2, 8'h00, 8'hff, 1'b1);
        // valid entry, no byte differs, yet a different checksum
        send_byte(3'd2, 8'h11, 8'h11, 1'b0);
        send_byte(3'd2, 8'h11, 8'h11, 1'b1);

        // random phases: free flow, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            target = tracker.bytes_seen + PHASE_BYTES;
            while (tracker.bytes_seen < target) begin
                b    = $urandom_range(0, BLOCK_COUNT - 1);
                pick = $urandom_range(99);
                if (!image_set[b] || (pick >= 60 && pick < 80)) begin
                    fill_image(b);
                end
                if (pick < 90) begin
                    scan_image(b, ($urandom_range(1) != 0) ? 0 : 20, pick >= 80);
                end else begin
                    noise_burst();
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain, then keep waiting for anything stray
        while (tracker.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (tracker.pending() != 0) begin
            tracker.errors++;
            $display("%0t: %0d results never arrived", $time, tracker.pending());
        end

        $display("run: %0d byte transfers, %0d block verdicts (%0d kept, %0d rewrites)",
                 tracker.bytes_seen, tracker.verdicts_seen, tracker.kept_count,
                 tracker.rewrite_count);
        $display("run: free flow, sender gaps, receiver stalls and mixed idling covered");
        if (tracker.errors == 0) begin
            $display("block_scrub_crc_compare_unit_tb: done, clean");
        end else begin
            $display("block_scrub_crc_compare_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
